// File: src/msrq_pkg.sv
// shared types, constants and helpers of the message slot ring queue
`timescale 1ns / 1ps
`default_nettype none

package msrq_pkg;

   localparam int RING_SLOTS_DEF = 16;
   localparam int SLOT_WORDS_DEF = 32;

   // lengths, byte counters and the clamped depth all fit in nine bits
   localparam int LEN_W      = 9;
   localparam int NB_W       = 4;
   localparam int STATUS_W   = 3;
   localparam int WORD_BITS  = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TDATA_W    = 80;

   localparam logic [LEN_W-1:0] SLOT_BYTES_RESET = 9'd260;
   localparam logic [LEN_W-1:0] SLOT_BYTES_MAX   = 9'd260;
   localparam logic [LEN_W-1:0] HEADER_BYTES     = 9'd4;
   localparam logic [4:0]       RING_DEPTH_RESET = 5'd16;

   localparam logic REG_SLOT_BYTES = 1'b0;
   localparam logic REG_RING_DEPTH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LONG   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SMALL  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_STAGED = 3'd5;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_FULL = 2'd1;
   localparam logic [1:0] ERR_LONG = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0] payload_limit;
      logic [LEN_W-1:0] depth;
   } cfg_type;

   // keeps the low nb bytes of a word
   function automatic logic [WORD_BITS-1:0] byte_mask(input logic [NB_W-1:0] nb);
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (NB_W'(i) < nb) begin
            m[i*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: src/msrq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module msrq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/msrq_csr.sv
// configuration registers and the derived payload limit and ring depth
`timescale 1ns / 1ps
`default_nettype none

module msrq_csr #(
   parameter int RING_SLOTS = msrq_pkg::RING_SLOTS_DEF,
   parameter int SLOT_WORDS = msrq_pkg::SLOT_WORDS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [msrq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [msrq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [msrq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready,
   output msrq_pkg::cfg_type                        cfg
);

   localparam int CapBytes = SLOT_WORDS * 8;

   logic [msrq_pkg::LEN_W-1:0] slot_bytes_ff, slot_bytes_in;
   logic [4:0]                 ring_depth_ff, ring_depth_in;
   logic                       wr_hit;
   logic                       reg_sel;
   logic [msrq_pkg::LEN_W-1:0] sb_sat, payload, depth;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      slot_bytes_in = slot_bytes_ff;
      ring_depth_in = ring_depth_ff;
      if (wr_hit) begin
         case (reg_sel)
            msrq_pkg::REG_SLOT_BYTES: slot_bytes_in = csr_pwdata[msrq_pkg::LEN_W-1:0];
            msrq_pkg::REG_RING_DEPTH: ring_depth_in = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_bytes_ff <= msrq_pkg::SLOT_BYTES_RESET;
         ring_depth_ff <= msrq_pkg::RING_DEPTH_RESET;
      end else begin
         slot_bytes_ff <= slot_bytes_in;
         ring_depth_ff <= ring_depth_in;
      end
   end

   always_comb begin
      case (reg_sel)
         msrq_pkg::REG_SLOT_BYTES:
            csr_prdata = msrq_pkg::CSR_DATA_W'(slot_bytes_ff);
         msrq_pkg::REG_RING_DEPTH:
            csr_prdata = msrq_pkg::CSR_DATA_W'(ring_depth_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // payload limit: slot size less the length header, bounded by the slot storage
   always_comb begin
      sb_sat  = (slot_bytes_ff > msrq_pkg::SLOT_BYTES_MAX) ?
                msrq_pkg::SLOT_BYTES_MAX : slot_bytes_ff;
      payload = (sb_sat < msrq_pkg::HEADER_BYTES) ? '0 : sb_sat - msrq_pkg::HEADER_BYTES;
      if ({1'b0, payload} > 10'(CapBytes)) begin
         payload = msrq_pkg::LEN_W'(CapBytes);
      end
      depth = msrq_pkg::LEN_W'(ring_depth_ff);
      if (depth < 9'd2) begin
         depth = 9'd2;
      end
      if (depth > msrq_pkg::LEN_W'(RING_SLOTS)) begin
         depth = msrq_pkg::LEN_W'(RING_SLOTS);
      end
      cfg.payload_limit = payload;
      cfg.depth         = depth;
   end

endmodule

`default_nettype wire

// File: src/msrq_ctrl.sv
// push staging, batch commit and poll sequencing around the slot memories
`timescale 1ns / 1ps
`default_nettype none

module msrq_ctrl #(
   parameter int RING_SLOTS = msrq_pkg::RING_SLOTS_DEF,
   parameter int SLOT_WORDS = msrq_pkg::SLOT_WORDS_DEF,
   localparam int IDX_W  = $clog2(RING_SLOTS),
   localparam int WORD_W = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1,
   localparam int ADDR_W = $clog2(RING_SLOTS * SLOT_WORDS)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire msrq_pkg::cfg_type                    cfg,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic                                 in_opcode,
   input  wire logic [msrq_pkg::WORD_BITS-1:0]       in_data,
   input  wire logic [msrq_pkg::NB_W-1:0]            in_count,
   input  wire logic                                 in_eom,
   input  wire logic                                 in_eob,
   input  wire logic [msrq_pkg::LEN_W-1:0]           in_cap,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [msrq_pkg::WORD_BITS-1:0]       out_word,
   output logic      [msrq_pkg::NB_W-1:0]            out_bytes,
   output logic      [msrq_pkg::LEN_W-1:0]           out_length,
   output logic      [msrq_pkg::STATUS_W-1:0]        out_status,
   output logic                                      out_last,
   output logic                                      store_wr_en,
   output logic      [ADDR_W-1:0]                    store_wr_addr,
   output logic      [msrq_pkg::WORD_BITS-1:0]       store_wr_data,
   output logic      [ADDR_W-1:0]                    store_rd_addr,
   input  wire logic [msrq_pkg::WORD_BITS-1:0]       store_rd_data,
   output logic                                      len_wr_en,
   output logic      [IDX_W-1:0]                     len_wr_addr,
   output logic      [msrq_pkg::LEN_W-1:0]           len_wr_data,
   output logic      [IDX_W-1:0]                     len_rd_addr,
   input  wire logic [msrq_pkg::LEN_W-1:0]           len_rd_data
);

   localparam int CapBytes = SLOT_WORDS * 8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HIGH,
      S_LEN,
      S_RD,
      S_DATA
   } state_type;

   state_type                        state_ff, state_in;
   logic [IDX_W-1:0]                 prod_ff, prod_in;
   logic [IDX_W-1:0]                 cons_ff, cons_in;
   logic [IDX_W-1:0]                 stage_ff, stage_in;
   logic [msrq_pkg::LEN_W-1:0]       bw_ff, bw_in;
   logic [1:0]                       err_ff, err_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [msrq_pkg::WORD_BITS-1:0]   acc_ff, acc_in;
   logic [msrq_pkg::WORD_BITS-1:0]   high_ff, high_in;
   logic [ADDR_W-1:0]                high_addr_ff, high_addr_in;
   logic [msrq_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [msrq_pkg::LEN_W-1:0]       rem_ff, rem_in;
   logic [msrq_pkg::LEN_W-1:0]       cap_ff, cap_in;
   logic [WORD_W-1:0]                widx_ff, widx_in;
   logic [msrq_pkg::WORD_BITS-1:0]   word_ff, word_in;
   logic [msrq_pkg::NB_W-1:0]        nb_ff, nb_in;
   logic [msrq_pkg::LEN_W-1:0]       mlen_ff, mlen_in;
   logic [msrq_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic                             last_ff, last_in;

   logic                             out_free, accept;
   logic [msrq_pkg::NB_W-1:0]        n_sat;
   logic [9:0]                       bw_sum;
   logic                             over, full, push_ok;
   logic [1:0]                       err_new;
   logic [2:0]                       sh;
   logic [4:0]                       span;
   logic [2*msrq_pkg::WORD_BITS-1:0] merged;
   logic [ADDR_W-1:0]                push_addr;
   logic [IDX_W-1:0]                 stage_next;
   logic [msrq_pkg::LEN_W-1:0]       bw_new;
   logic [msrq_pkg::LEN_W-1:0]       rd_len;
   logic [msrq_pkg::NB_W-1:0]        rd_nb;

   function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i,
                                            input logic [msrq_pkg::LEN_W-1:0] d);
      logic [msrq_pkg::LEN_W-1:0] nx;
      nx = msrq_pkg::LEN_W'(i) + 9'd1;
      return (nx >= d) ? '0 : nx[IDX_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] slot_base(input logic [IDX_W-1:0] s);
      return ADDR_W'(s) * ADDR_W'(SLOT_WORDS);
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // push datapath: new bytes land after the bytes already in the partial word
   always_comb begin
      n_sat     = (in_count > 4'd8) ? 4'd8 : in_count;
      bw_sum    = 10'(bw_ff) + 10'(n_sat);
      over      = bw_sum > 10'(cfg.payload_limit);
      full      = adv(stage_ff, cfg.depth) == cons_ff;
      push_ok   = (err_ff == msrq_pkg::ERR_NONE) && !over && !full;
      if (err_ff != msrq_pkg::ERR_NONE) begin
         err_new = err_ff;
      end else if (over) begin
         err_new = msrq_pkg::ERR_LONG;
      end else if (full) begin
         err_new = msrq_pkg::ERR_FULL;
      end else begin
         err_new = msrq_pkg::ERR_NONE;
      end
      sh        = bw_ff[2:0];
      span      = 5'(sh) + 5'(n_sat);
      merged    = ({{msrq_pkg::WORD_BITS{1'b0}}, in_data & msrq_pkg::byte_mask(n_sat)}
                   << {sh, 3'b000}) | {{msrq_pkg::WORD_BITS{1'b0}}, acc_ff};
      push_addr = slot_base(stage_ff) + ADDR_W'(bw_ff[WORD_W+2:3]);
      bw_new    = push_ok ? bw_sum[msrq_pkg::LEN_W-1:0] : bw_ff;
      stage_next = adv(stage_ff, cfg.depth);
   end

   // poll datapath
   always_comb begin
      rd_len = len_rd_data;
      if ({1'b0, rd_len} > 10'(CapBytes)) begin
         rd_len = msrq_pkg::LEN_W'(CapBytes);
      end
      rd_nb = (rem_ff > 9'd8) ? 4'd8 : rem_ff[msrq_pkg::NB_W-1:0];
   end

   assign len_rd_addr   = cons_ff;
   assign store_rd_addr = slot_base(cons_ff) + ADDR_W'(widx_ff);

   always_comb begin
      state_in     = state_ff;
      prod_in      = prod_ff;
      cons_in      = cons_ff;
      stage_in     = stage_ff;
      bw_in        = bw_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      high_in      = high_ff;
      high_addr_in = high_addr_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      cap_in       = cap_ff;
      widx_in      = widx_ff;
      word_in      = word_ff;
      nb_in        = nb_ff;
      mlen_in      = mlen_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      store_wr_en   = 1'b0;
      store_wr_addr = push_addr;
      store_wr_data = merged[msrq_pkg::WORD_BITS-1:0];
      len_wr_en     = 1'b0;
      len_wr_addr   = stage_ff;
      len_wr_data   = bw_new;

      case (state_ff)
         S_IDLE: begin
            if (accept && !in_opcode) begin
               word_in      = '0;
               nb_in        = '0;
               mlen_in      = '0;
               last_in      = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = msrq_pkg::ST_STAGED;
               bw_in        = bw_new;
               err_in       = err_new;
               if (push_ok) begin
                  acc_in = (span >= 5'd8) ? merged[2*msrq_pkg::WORD_BITS-1:msrq_pkg::WORD_BITS]
                                          : merged[msrq_pkg::WORD_BITS-1:0];
                  if (n_sat != '0) begin
                     store_wr_en = 1'b1;
                  end
                  // bytes spilled into the following word go out next cycle
                  if (span > 5'd8) begin
                     high_in      = merged[2*msrq_pkg::WORD_BITS-1:msrq_pkg::WORD_BITS];
                     high_addr_in = push_addr + ADDR_W'(1);
                     state_in     = S_HIGH;
                  end
               end
               if (in_eom || in_eob) begin
                  if (err_new == msrq_pkg::ERR_NONE) begin
                     len_wr_en = 1'b1;
                     stage_in  = stage_next;
                  end
                  bw_in  = '0;
                  acc_in = '0;
               end
               if (in_eob) begin
                  status_in = msrq_pkg::STATUS_W'(err_new);
                  if (err_new == msrq_pkg::ERR_NONE) begin
                     prod_in  = stage_next;
                     stage_in = stage_next;
                  end else begin
                     stage_in = prod_ff;
                  end
                  err_in = msrq_pkg::ERR_NONE;
               end
            end else if (accept) begin
               cap_in = in_cap;
               if (prod_ff == cons_ff) begin
                  word_in      = '0;
                  nb_in        = '0;
                  mlen_in      = '0;
                  status_in    = msrq_pkg::ST_EMPTY;
                  last_in      = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_LEN;
               end
            end
         end
         S_HIGH: begin
            store_wr_en   = 1'b1;
            store_wr_addr = high_addr_ff;
            store_wr_data = high_ff;
            state_in      = S_IDLE;
         end
         S_LEN: begin
            word_in = '0;
            nb_in   = '0;
            last_in = 1'b1;
            if (cap_ff < rd_len) begin
               // refused: message stays in the ring
               mlen_in      = rd_len;
               status_in    = msrq_pkg::ST_SMALL;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (rd_len == '0) begin
               mlen_in      = '0;
               status_in    = msrq_pkg::ST_OK;
               rsp_valid_in = 1'b1;
               cons_in      = adv(cons_ff, cfg.depth);
               state_in     = S_IDLE;
            end else begin
               len_in   = rd_len;
               rem_in   = rd_len;
               widx_in  = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (out_free) begin
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            word_in      = store_rd_data & msrq_pkg::byte_mask(rd_nb);
            nb_in        = rd_nb;
            mlen_in      = len_ff;
            status_in    = msrq_pkg::ST_OK;
            last_in      = rem_ff <= 9'd8;
            rsp_valid_in = 1'b1;
            if (rem_ff <= 9'd8) begin
               cons_in  = adv(cons_ff, cfg.depth);
               state_in = S_IDLE;
            end else begin
               rem_in   = rem_ff - 9'd8;
               widx_in  = widx_ff + WORD_W'(1);
               state_in = S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prod_ff      <= '0;
         cons_ff      <= '0;
         stage_ff     <= '0;
         bw_ff        <= '0;
         err_ff       <= msrq_pkg::ERR_NONE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prod_ff      <= prod_in;
         cons_ff      <= cons_in;
         stage_ff     <= stage_in;
         bw_ff        <= bw_in;
         err_ff       <= err_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      high_ff      <= high_in;
      high_addr_ff <= high_addr_in;
      len_ff       <= len_in;
      rem_ff       <= rem_in;
      cap_ff       <= cap_in;
      widx_ff      <= widx_in;
      word_ff      <= word_in;
      nb_ff        <= nb_in;
      mlen_ff      <= mlen_in;
      status_ff    <= status_in;
      last_ff      <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_word   = word_ff;
   assign out_bytes  = nb_ff;
   assign out_length = mlen_ff;
   assign out_status = status_ff;
   assign out_last   = last_ff;

endmodule

`default_nettype wire

// File: src/message_slot_ring_queue.sv
// top level of the message slot ring queue
`timescale 1ns / 1ps
`default_nettype none

// Ring of RING_SLOTS message slots of SLOT_WORDS 64-bit words each, held in a
// single-port-write slot memory and a small length memory, both with registered
// read data. A push transaction (tuser[0] low) returns one result; bytes that
// spill past a word boundary are written to the next word in the S_HIGH state,
// since the slot memory takes one write per cycle. A batch becomes visible to
// polls only on its end_of_batch word, and a full ring or oversize message
// drops the whole batch. A poll answers from the idle state when the ring is
// empty; else it reads the slot length (S_LEN) and answers there if the message
// is refused or empty, else runs a read state and a load of the output register
// (S_RD, S_DATA) per message word. One item is in work at a time, and a result
// waiting in the output register holds back the next request until taken.
// Registers: slot_bytes at address 0 (reset 260), ring_depth at 4 (reset 16).
// No clearing pass is needed after reset.
module message_slot_ring_queue #(
   parameter int RING_SLOTS = msrq_pkg::RING_SLOTS_DEF,
   parameter int SLOT_WORDS = msrq_pkg::SLOT_WORDS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // data_word[63:0], byte_count[67:64], reader_capacity[76:68], zero fill
   input  wire logic [msrq_pkg::TDATA_W-1:0]      req_tdata,
   // opcode[0], end_of_batch[1]
   input  wire logic [1:0]                        req_tuser,
   // end_of_message
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // read_word[63:0], read_bytes[67:64], message_length[76:68], status[79:77]
   output logic      [msrq_pkg::TDATA_W-1:0]      rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [msrq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [msrq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [msrq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   localparam int IDX_W       = $clog2(RING_SLOTS);
   localparam int STORE_DEPTH = RING_SLOTS * SLOT_WORDS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   msrq_pkg::cfg_type                   cfg;
   logic                                store_wr_en;
   logic [ADDR_W-1:0]                   store_wr_addr;
   logic [msrq_pkg::WORD_BITS-1:0]      store_wr_data;
   logic [ADDR_W-1:0]                   store_rd_addr;
   logic [msrq_pkg::WORD_BITS-1:0]      store_rd_data;
   logic                                len_wr_en;
   logic [IDX_W-1:0]                    len_wr_addr;
   logic [msrq_pkg::LEN_W-1:0]          len_wr_data;
   logic [IDX_W-1:0]                    len_rd_addr;
   logic [msrq_pkg::LEN_W-1:0]          len_rd_data;
   logic [msrq_pkg::WORD_BITS-1:0]      out_word;
   logic [msrq_pkg::NB_W-1:0]           out_bytes;
   logic [msrq_pkg::LEN_W-1:0]          out_length;
   logic [msrq_pkg::STATUS_W-1:0]       out_status;

   msrq_csr #(
      .RING_SLOTS (RING_SLOTS),
      .SLOT_WORDS (SLOT_WORDS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   msrq_ram #(
      .WIDTH (msrq_pkg::WORD_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   msrq_ram #(
      .WIDTH (msrq_pkg::LEN_W),
      .DEPTH (RING_SLOTS)
   ) u_length (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (len_wr_data),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd_data)
   );

   msrq_ctrl #(
      .RING_SLOTS (RING_SLOTS),
      .SLOT_WORDS (SLOT_WORDS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .in_opcode     (req_tuser[0]),
      .in_data       (req_tdata[63:0]),
      .in_count      (req_tdata[67:64]),
      .in_eom        (req_tlast),
      .in_eob        (req_tuser[1]),
      .in_cap        (req_tdata[76:68]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .out_word      (out_word),
      .out_bytes     (out_bytes),
      .out_length    (out_length),
      .out_status    (out_status),
      .out_last      (rsp_tlast),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .len_wr_en     (len_wr_en),
      .len_wr_addr   (len_wr_addr),
      .len_wr_data   (len_wr_data),
      .len_rd_addr   (len_rd_addr),
      .len_rd_data   (len_rd_data)
   );

   assign rsp_tdata = {out_status, out_length, out_bytes, out_word};

endmodule

`default_nettype wire

// File: src/msrq_checker.sv
// port-level checks of the message slot ring queue and their binding
`timescale 1ns / 1ps
`default_nettype none

module msrq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [msrq_pkg::TDATA_W-1:0]  rsp_tdata,
   input wire logic                          rsp_tlast
);

   // a stalled result transaction keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // every status other than ok ends the results of its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[79:77] != msrq_pkg::ST_OK |-> rsp_tlast)
      else $error("error status on a non-final result");

   // words before the last one of a message are full and ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[67:64] == 4'd8 &&
                                  rsp_tdata[79:77] == msrq_pkg::ST_OK)
      else $error("partial word before end of message");

   // a result without valid bytes carries all-zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[67:64] == 4'd0 |-> rsp_tdata[63:0] == 64'd0)
      else $error("data on a result without bytes");

endmodule

bind message_slot_ring_queue msrq_checker u_msrq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
